/* rtl/helix_position_momentum_top_assert.svh */
// ----------------------------------------------------------------------------
// helix_position_momentum_top_assert.svh
// Assertion macros used by the helix extrapolation checker.
// ----------------------------------------------------------------------------
`ifndef HELIX_POSITION_MOMENTUM_TOP_ASSERT_SVH
`define HELIX_POSITION_MOMENTUM_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low
`define HPM_ASSERT_IMP(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("hpm assertion failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low
`define HPM_ASSERT_NXT(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("hpm assertion failed");

`endif

/* rtl/hpm_pkg.sv */
// ----------------------------------------------------------------------------
// hpm_pkg
// Widths, angle constants, arctangent table and shared arithmetic helpers
// for the helix position and momentum pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package hpm_pkg;

  localparam int unsigned LEN_W    = 32;  // Q16.16 lengths and outputs
  localparam int unsigned CW       = 34;  // CORDIC x/y, Q2.30 with headroom
  localparam int unsigned ZW       = 32;  // CORDIC residual angle, Q4.28
  localparam int unsigned PW       = 34;  // rounded product width
  localparam int unsigned ANG_W    = 35;  // angle sums before reduction
  localparam int unsigned DIV_BITS = 62;  // dividend bits |L|*|sin th|
  localparam int unsigned REM_W    = 33;  // divisor 4R and remainder
  localparam int unsigned QM_W     = 31;  // quotient modulo 2pi

  localparam logic signed [ANG_W-1:0] ANG_PI      = 35'sd843314857;
  localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 35'sd421657428;
  localparam logic signed [ANG_W-1:0] ANG_TWO_PI  = 35'sd1686629713;
  localparam logic signed [ANG_W-1:0] ANG_FOUR_PI = 35'sd3373259426;
  localparam logic [QM_W:0]           QM_TWO_PI   = 32'd1686629713;

  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam int                   ROUND_Q30   = 536870912;

  localparam logic signed [ZW-1:0] ATAN_TAB [32] = '{
    32'sd210828714, 32'sd124459457, 32'sd65760959, 32'sd33381290,
    32'sd16755422,  32'sd8385879,   32'sd4193963,  32'sd2097109,
    32'sd1048571,   32'sd524287,    32'sd262144,   32'sd131072,
    32'sd65536,     32'sd32768,     32'sd16384,    32'sd8192,
    32'sd4096,      32'sd2048,      32'sd1024,     32'sd512,
    32'sd256,       32'sd128,       32'sd64,       32'sd32,
    32'sd16,        32'sd8,         32'sd4,        32'sd2,
    32'sd1,         32'sd0,         32'sd0,        32'sd0
  };

  typedef enum logic [2:0] {
    REG_CENTER_X    = 3'd0,
    REG_CENTER_Y    = 3'd1,
    REG_CENTER_Z    = 3'd2,
    REG_RADIUS      = 3'd3,
    REG_START_ANGLE = 3'd4,
    REG_POLAR_ANGLE = 3'd5,
    REG_CHARGE_SIGN = 3'd6,
    REG_MOMENTUM    = 3'd7
  } cfg_reg_e;

  // Angle folded into [-pi/2, pi/2] with the sign flip it needs
  typedef struct packed {
    logic                 neg;
    logic signed [ZW-1:0] z;
  } fold_t;

  // Words riding along the divider chain
  typedef struct packed {
    logic                 turn_neg;
    logic signed [PW-1:0] pt;
    logic signed [PW-1:0] mz;
    logic signed [PW-1:0] pz;
  } div_side_t;

  // Words riding along the second rotation chain
  typedef struct packed {
    logic                 fold_neg;
    logic signed [PW-1:0] pt;
    logic signed [PW-1:0] mz;
    logic signed [PW-1:0] pz;
  } rot_side_t;

  // Q x Q2.30 product, rounded half up to the first operand's format
  function automatic logic signed [PW-1:0] mulq30(input logic signed [PW-1:0] a,
                                                 input logic signed [PW-1:0] b);
    logic signed [2*PW-1:0] p;
    p = a * b;
    p = p + (2*PW)'(ROUND_Q30);
    return p[PW+29:30];
  endfunction

  function automatic logic signed [LEN_W-1:0] sat32(input logic signed [PW+1:0] v);
    if (v > (PW+2)'(64'sd2147483647)) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -(PW+2)'(64'sd2147483648)) begin
      return 32'sh8000_0000;
    end
    return v[LEN_W-1:0];
  endfunction

  // Fold an angle in (-pi, pi] into the CORDIC range
  function automatic fold_t fold_angle(input logic signed [ANG_W-1:0] r);
    fold_t                   f;
    logic signed [ANG_W-1:0] t;
    f.neg = 1'b0;
    t     = r;
    if (r > ANG_HALF_PI) begin
      t     = r - ANG_PI;
      f.neg = 1'b1;
    end else if (r < -ANG_HALF_PI) begin
      t     = r + ANG_PI;
      f.neg = 1'b1;
    end
    f.z = t[ZW-1:0];
    return f;
  endfunction

endpackage

`default_nettype wire

/* rtl/hpm_cordic_cell.sv */
// ----------------------------------------------------------------------------
// hpm_cordic_cell
// One rotation-mode CORDIC micro-rotation, registered, with a side word
// carried along unchanged.
// ----------------------------------------------------------------------------
`default_nettype none

module hpm_cordic_cell import hpm_pkg::*; #(
  parameter int unsigned SHIFT  = 0,
  parameter int unsigned SIDE_W = 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 en_i,
  input  wire logic                 valid_i,
  input  wire logic signed [CW-1:0] x_i,
  input  wire logic signed [CW-1:0] y_i,
  input  wire logic signed [ZW-1:0] z_i,
  input  wire logic [SIDE_W-1:0]    side_i,
  output logic                      valid_o,
  output logic signed [CW-1:0]      x_o,
  output logic signed [CW-1:0]      y_o,
  output logic signed [ZW-1:0]      z_o,
  output logic [SIDE_W-1:0]         side_o
);

  localparam logic signed [ZW-1:0] ATAN = ATAN_TAB[SHIFT];

  logic signed [CW-1:0] x_sh, y_sh, x_d, y_d;
  logic signed [ZW-1:0] z_d;

  // Rotate toward zero residual angle
  always_comb begin
    x_sh = x_i >>> SHIFT;
    y_sh = y_i >>> SHIFT;
    if (!z_i[ZW-1]) begin
      x_d = x_i - y_sh;
      y_d = y_i + x_sh;
      z_d = z_i - ATAN;
    end else begin
      x_d = x_i + y_sh;
      y_d = y_i - x_sh;
      z_d = z_i + ATAN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_o    <= x_d;
      y_o    <= y_d;
      z_o    <= z_d;
      side_o <= side_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/hpm_div_cell.sv */
// ----------------------------------------------------------------------------
// hpm_div_cell
// One restoring division step. The quotient bit is folded at once into a
// running quotient modulo 2pi, so the full quotient is never kept.
// ----------------------------------------------------------------------------
`default_nettype none

module hpm_div_cell import hpm_pkg::*; #(
  parameter int unsigned SIDE_W = 1
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                en_i,
  input  wire logic                valid_i,
  input  wire logic [REM_W-1:0]    divisor_i,
  input  wire logic [REM_W-1:0]    rem_i,
  input  wire logic [DIV_BITS-1:0] num_i,
  input  wire logic [QM_W-1:0]     qm_i,
  input  wire logic [SIDE_W-1:0]   side_i,
  output logic                     valid_o,
  output logic [REM_W-1:0]         rem_o,
  output logic [DIV_BITS-1:0]      num_o,
  output logic [QM_W-1:0]          qm_o,
  output logic [SIDE_W-1:0]        side_o
);

  logic [REM_W:0]   trial, diff;
  logic             qbit;
  logic [REM_W-1:0] rem_d;
  logic [QM_W:0]    qm2, qm_sub;
  logic [QM_W-1:0]  qm_d;

  // Bring down the next dividend bit, subtract if it fits
  always_comb begin
    trial  = {rem_i, num_i[DIV_BITS-1]};
    diff   = trial - {1'b0, divisor_i};
    qbit   = (trial >= {1'b0, divisor_i});
    rem_d  = qbit ? diff[REM_W-1:0] : trial[REM_W-1:0];
    qm2    = {qm_i, qbit};
    qm_sub = qm2 - QM_TWO_PI;
    qm_d   = (qm2 >= QM_TWO_PI) ? qm_sub[QM_W-1:0] : qm2[QM_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o  <= rem_d;
      num_o  <= {num_i[DIV_BITS-2:0], 1'b0};
      qm_o   <= qm_d;
      side_o <= side_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/helix_position_momentum_top.sv */
// ----------------------------------------------------------------------------
// helix_position_momentum_top
// Point and momentum on a helix for a signed track length: CORDIC for the
// polar angle, a division chain for the turning angle, CORDIC for the
// azimuth, then products, sums and saturation.
// ----------------------------------------------------------------------------
//  channel   dir  signals                               word
//  s_axis    in   tvalid tready tdata[31:0]             track_length
//  m_axis    out  tvalid tready tdata[191:0] tuser      positions, momenta
//  cfg       in   cfg_valid_i cfg_ready_o index data    one register
//
//  One word per clock while the output word is taken, through the cell chains
//  (two CORDIC rows and a 62-cell division row).
//  The whole pipeline holds while the output word waits; one input word is
//  still taken into a skid register during that time.
//  Reset clears valid bits and loads the register reset values.
// ----------------------------------------------------------------------------
`default_nettype none

module helix_position_momentum_top import hpm_pkg::*; #(
  parameter int unsigned CORDIC_STAGES = 24
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           s_axis_tvalid,
  output logic                s_axis_tready,
  input  wire logic [31:0]    s_axis_tdata,   // [31:0] track_length
  output logic                m_axis_tvalid,
  input  wire logic           m_axis_tready,
  output logic [191:0]        m_axis_tdata,   // pos_x pos_y pos_z mom_x mom_y mom_z
  output logic                m_axis_tuser,   // bad_radius
  input  wire logic           cfg_valid_i,
  output logic                cfg_ready_o,
  input  wire logic [2:0]     cfg_index_i,
  input  wire logic [31:0]    cfg_data_i
);

  localparam int unsigned DSIDE_W = $bits(div_side_t);
  localparam int unsigned RSIDE_W = $bits(rot_side_t);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic signed [31:0] cfg_cx_q, cfg_cy_q, cfg_cz_q;
  logic [30:0]        cfg_r_q;
  logic signed [30:0] cfg_a0_q;
  logic [29:0]        cfg_pol_q;
  logic               cfg_chg_q;
  logic [30:0]        cfg_mom_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_cx_q  <= '0;
      cfg_cy_q  <= '0;
      cfg_cz_q  <= '0;
      cfg_r_q   <= 31'd65536;
      cfg_a0_q  <= '0;
      cfg_pol_q <= 30'd421657428;
      cfg_chg_q <= 1'b0;
      cfg_mom_q <= 31'd65536;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_CENTER_X:    cfg_cx_q  <= cfg_data_i;
        REG_CENTER_Y:    cfg_cy_q  <= cfg_data_i;
        REG_CENTER_Z:    cfg_cz_q  <= cfg_data_i;
        REG_RADIUS:      cfg_r_q   <= cfg_data_i[30:0];
        REG_START_ANGLE: cfg_a0_q  <= cfg_data_i[30:0];
        REG_POLAR_ANGLE: cfg_pol_q <= cfg_data_i[29:0];
        REG_CHARGE_SIGN: cfg_chg_q <= cfg_data_i[0];
        REG_MOMENTUM:    cfg_mom_q <= cfg_data_i[30:0];
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Input skid and entry register
  // --------------------------------------------------------------------------
  logic              adv;
  logic              in_acc;
  logic              skid_valid_q;
  logic [31:0]       skid_q;
  logic              s0_valid_q;
  logic signed [31:0] s0_len_q;

  assign s_axis_tready = !skid_valid_q;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign adv           = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_valid_q <= 1'b0;
      s0_valid_q   <= 1'b0;
    end else if (adv) begin
      skid_valid_q <= 1'b0;
      s0_valid_q   <= skid_valid_q || in_acc;
    end else if (in_acc) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s0_len_q <= skid_valid_q ? skid_q : s_axis_tdata;
    end else if (in_acc) begin
      skid_q <= s_axis_tdata;
    end
  end

  // --------------------------------------------------------------------------
  // Polar angle rotation row
  // --------------------------------------------------------------------------
  logic signed [ANG_W-1:0] pol_w, pol_r;
  fold_t                   pol_f;

  // Fold the polar angle, a static value from configuration
  always_comb begin
    pol_w = signed'({5'b0, cfg_pol_q});
    pol_r = (pol_w > ANG_PI) ? pol_w - ANG_TWO_PI : pol_w;
    pol_f = fold_angle(pol_r);
  end

  logic                 c1_v [CORDIC_STAGES+1];
  logic signed [CW-1:0] c1_x [CORDIC_STAGES+1];
  logic signed [CW-1:0] c1_y [CORDIC_STAGES+1];
  logic signed [ZW-1:0] c1_z [CORDIC_STAGES+1];
  logic [31:0]          c1_s [CORDIC_STAGES+1];

  assign c1_v[0] = s0_valid_q;
  assign c1_x[0] = CORDIC_GAIN;
  assign c1_y[0] = '0;
  assign c1_z[0] = pol_f.z;
  assign c1_s[0] = s0_len_q;

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_c1
    hpm_cordic_cell #(.SHIFT(i), .SIDE_W(32)) u_cell (
      .clk_i, .rst_ni, .en_i(adv),
      .valid_i(c1_v[i]), .x_i(c1_x[i]), .y_i(c1_y[i]), .z_i(c1_z[i]), .side_i(c1_s[i]),
      .valid_o(c1_v[i+1]), .x_o(c1_x[i+1]), .y_o(c1_y[i+1]), .z_o(c1_z[i+1]),
      .side_o(c1_s[i+1])
    );
  end

  // --------------------------------------------------------------------------
  // Product stage: dividend, transverse and longitudinal terms
  // --------------------------------------------------------------------------
  logic signed [CW-1:0]    st, ct;
  logic signed [PW-1:0]    len_w;
  logic [32:0]             mag_l;
  logic [CW-1:0]           mag_s;
  logic [66:0]             num_full;
  logic                    p_valid_q;
  logic [DIV_BITS-1:0]     p_num_q;
  div_side_t               p_side_q;

  always_comb begin
    st       = pol_f.neg ? -c1_y[CORDIC_STAGES] : c1_y[CORDIC_STAGES];
    ct       = pol_f.neg ? -c1_x[CORDIC_STAGES] : c1_x[CORDIC_STAGES];
    len_w    = PW'(signed'(c1_s[CORDIC_STAGES]));
    mag_l    = len_w[PW-1] ? 33'(-len_w) : 33'(len_w);
    mag_s    = st[CW-1] ? -st : st;
    num_full = 67'(mag_l) * 67'(mag_s);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
    end else if (adv) begin
      p_valid_q <= c1_v[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p_num_q           <= num_full[DIV_BITS-1:0];
      p_side_q.pt       <= mulq30(signed'({3'b0, cfg_mom_q}), st);
      p_side_q.mz       <= mulq30(signed'({3'b0, cfg_mom_q}), ct);
      p_side_q.pz       <= mulq30(len_w, ct);
      p_side_q.turn_neg <= (len_w[PW-1] != st[CW-1]) != cfg_chg_q;
    end
  end

  // --------------------------------------------------------------------------
  // Division row: turning step modulo 2pi
  // --------------------------------------------------------------------------
  logic [REM_W-1:0]    divisor;
  logic                dv_v [DIV_BITS+1];
  logic [REM_W-1:0]    dv_r [DIV_BITS+1];
  logic [DIV_BITS-1:0] dv_n [DIV_BITS+1];
  logic [QM_W-1:0]     dv_q [DIV_BITS+1];
  logic [DSIDE_W-1:0]  dv_s [DIV_BITS+1];

  assign divisor = {cfg_r_q, 2'b00};
  assign dv_v[0] = p_valid_q;
  assign dv_r[0] = '0;
  assign dv_n[0] = p_num_q;
  assign dv_q[0] = '0;
  assign dv_s[0] = p_side_q;

  for (genvar i = 0; i < DIV_BITS; i++) begin : g_div
    hpm_div_cell #(.SIDE_W(DSIDE_W)) u_cell (
      .clk_i, .rst_ni, .en_i(adv), .divisor_i(divisor),
      .valid_i(dv_v[i]), .rem_i(dv_r[i]), .num_i(dv_n[i]), .qm_i(dv_q[i]),
      .side_i(dv_s[i]),
      .valid_o(dv_v[i+1]), .rem_o(dv_r[i+1]), .num_o(dv_n[i+1]), .qm_o(dv_q[i+1]),
      .side_o(dv_s[i+1])
    );
  end

  // --------------------------------------------------------------------------
  // Angle reduction into (-pi, pi], two stages
  // --------------------------------------------------------------------------
  div_side_t               d_side;
  logic signed [ANG_W-1:0] a0_w, qm_w, turn_v, turn_w;
  logic                    w1_valid_q, w2_valid_q;
  logic signed [ANG_W-1:0] w1_q, w2, w2_r, w2_q;
  div_side_t               w1_side_q, w2_side_q;

  always_comb begin
    d_side = div_side_t'(dv_s[DIV_BITS]);
    a0_w   = ANG_W'(cfg_a0_q);
    qm_w   = signed'({4'b0, dv_q[DIV_BITS]});
    turn_v = d_side.turn_neg ? a0_w + qm_w : a0_w - qm_w;
    turn_w = turn_v + ANG_FOUR_PI;
    w2     = (w1_q >= ANG_TWO_PI) ? w1_q - ANG_TWO_PI : w1_q;
    w2_r   = (w2 > ANG_PI) ? w2 - ANG_TWO_PI : w2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w1_valid_q <= 1'b0;
      w2_valid_q <= 1'b0;
    end else if (adv) begin
      w1_valid_q <= dv_v[DIV_BITS];
      w2_valid_q <= w1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      w1_q      <= (turn_w >= ANG_FOUR_PI) ? turn_w - ANG_FOUR_PI : turn_w;
      w1_side_q <= d_side;
      w2_q      <= w2_r;
      w2_side_q <= w1_side_q;
    end
  end

  // --------------------------------------------------------------------------
  // Azimuth rotation row
  // --------------------------------------------------------------------------
  fold_t     az_f;
  rot_side_t rot_in;

  always_comb begin
    az_f            = fold_angle(w2_q);
    rot_in.fold_neg = az_f.neg;
    rot_in.pt       = w2_side_q.pt;
    rot_in.mz       = w2_side_q.mz;
    rot_in.pz       = w2_side_q.pz;
  end

  logic                 c2_v [CORDIC_STAGES+1];
  logic signed [CW-1:0] c2_x [CORDIC_STAGES+1];
  logic signed [CW-1:0] c2_y [CORDIC_STAGES+1];
  logic signed [ZW-1:0] c2_z [CORDIC_STAGES+1];
  logic [RSIDE_W-1:0]   c2_s [CORDIC_STAGES+1];

  assign c2_v[0] = w2_valid_q;
  assign c2_x[0] = CORDIC_GAIN;
  assign c2_y[0] = '0;
  assign c2_z[0] = az_f.z;
  assign c2_s[0] = rot_in;

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_c2
    hpm_cordic_cell #(.SHIFT(i), .SIDE_W(RSIDE_W)) u_cell (
      .clk_i, .rst_ni, .en_i(adv),
      .valid_i(c2_v[i]), .x_i(c2_x[i]), .y_i(c2_y[i]), .z_i(c2_z[i]), .side_i(c2_s[i]),
      .valid_o(c2_v[i+1]), .x_o(c2_x[i+1]), .y_o(c2_y[i+1]), .z_o(c2_z[i+1]),
      .side_o(c2_s[i+1])
    );
  end

  // --------------------------------------------------------------------------
  // Final products
  // --------------------------------------------------------------------------
  rot_side_t            rot_out;
  logic signed [CW-1:0] sa, ca;
  logic signed [PW-1:0] r_w;
  logic                 m_valid_q;
  logic signed [PW-1:0] m_px_q, m_py_q, m_mx_q, m_my_q, m_pz_q, m_mz_q;

  always_comb begin
    rot_out = rot_side_t'(c2_s[CORDIC_STAGES]);
    sa      = rot_out.fold_neg ? -c2_y[CORDIC_STAGES] : c2_y[CORDIC_STAGES];
    ca      = rot_out.fold_neg ? -c2_x[CORDIC_STAGES] : c2_x[CORDIC_STAGES];
    r_w     = signed'({3'b0, cfg_r_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (adv) begin
      m_valid_q <= c2_v[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_px_q <= mulq30(r_w, ca);
      m_py_q <= mulq30(r_w, sa);
      m_mx_q <= mulq30(rot_out.pt, sa);
      m_my_q <= mulq30(rot_out.pt, ca);
      m_pz_q <= rot_out.pz;
      m_mz_q <= rot_out.mz;
    end
  end

  // --------------------------------------------------------------------------
  // Output register: sums, charge sign, saturation
  // --------------------------------------------------------------------------
  logic               bad_r;
  logic signed [PW-1:0] mx_s, my_s;
  logic [191:0]       out_d;
  logic               out_valid_q;
  logic [191:0]       out_data_q;
  logic               out_bad_q;

  always_comb begin
    bad_r = (cfg_r_q == '0);
    mx_s  = cfg_chg_q ? -m_mx_q : m_mx_q;
    my_s  = cfg_chg_q ? m_my_q : -m_my_q;
    out_d[31:0]    = sat32((PW+2)'(cfg_cx_q) + (PW+2)'(m_px_q));
    out_d[63:32]   = sat32((PW+2)'(cfg_cy_q) + (PW+2)'(m_py_q));
    out_d[95:64]   = sat32((PW+2)'(cfg_cz_q) + (PW+2)'(m_pz_q));
    out_d[127:96]  = sat32((PW+2)'(mx_s));
    out_d[159:128] = sat32((PW+2)'(my_s));
    out_d[191:160] = sat32((PW+2)'(m_mz_q));
    if (bad_r) begin
      out_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= m_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q <= out_d;
      out_bad_q  <= bad_r;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_bad_q;

endmodule

`default_nettype wire

/* rtl/hpm_checker.sv */
// ----------------------------------------------------------------------------
// hpm_checker
// Port-level checks for the helix extrapolation block, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "helix_position_momentum_top_assert.svh"

module hpm_checker (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         s_axis_tvalid,
  input wire logic         s_axis_tready,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [191:0] m_axis_tdata,
  input wire logic         m_axis_tuser,
  input wire logic         cfg_valid_i,
  input wire logic         cfg_ready_o
);

  // A held output word keeps its value
  `HPM_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // A zero radius word carries all-zero results
  `HPM_ASSERT_IMP(a_bad_zero, m_axis_tvalid && m_axis_tuser, m_axis_tdata == '0)

  // A word taken while the output is held fills the skid, closing the input
  `HPM_ASSERT_NXT(a_skid_full, s_axis_tvalid && s_axis_tready && m_axis_tvalid && !m_axis_tready, !s_axis_tready)

  // Register writes are never refused
  `HPM_ASSERT_IMP(a_cfg_ready, cfg_valid_i, cfg_ready_o)

endmodule

bind helix_position_momentum_top hpm_checker u_hpm_checker (.*);

`default_nettype wire
